// ===== hdl/windowed_detector_rate_counter_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the windowed detector rate counter
// ---------------------------------------------------------------------------
`ifndef WINDOWED_DETECTOR_RATE_COUNTER_TOP_MACROS_SVH
`define WINDOWED_DETECTOR_RATE_COUNTER_TOP_MACROS_SVH

// property checked out of reset only
`define WDRC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property that covers the reset cycles as well
`define WDRC_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/wdrc_pkg.sv =====
// ---------------------------------------------------------------------------
// wdrc_pkg
// Shared types, constants and helpers of the windowed detector rate counter.
// ---------------------------------------------------------------------------
package wdrc_pkg;

    localparam int COUNTER_BITS = 32;
    localparam int DETECTORS    = 4;
    localparam int REPORTED     = 4;
    localparam int WORD_W       = 32;
    localparam int TIME_W       = 49;
    localparam int WEND_W       = TIME_W + 1;
    localparam int LIMIT_W      = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = TIME_W;
    localparam int TIME_LO_BIT  = 15;

    localparam logic [TIME_W-1:0]  WINDOW_RESET = TIME_W'(64'h1_0000_0000);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(1);

    typedef logic [COUNTER_BITS-1:0] t_cnt;
    typedef logic [WORD_W-1:0]       t_word;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_ROUND_LIMIT   = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic [TIME_W-1:0]  window_length;
        logic [LIMIT_W-1:0] round_limit;
    } t_cfg;

    typedef struct packed {
        logic  valid;
        t_word high_word;
        t_word low_word;
    } t_evt;

    // saturating increment
    function automatic t_cnt sat_inc(input t_cnt c);
        return (c == '1) ? c : c + t_cnt'(1);
    endfunction

    // reported counts are 32 bits whatever the counter width
    function automatic t_word clamp_report(input t_cnt c);
        logic [63:0] w;
        w = 64'(c);
        return (w > 64'hFFFF_FFFF) ? '1 : w[WORD_W-1:0];
    endfunction

endpackage

// ===== hdl/windowed_detector_rate_counter_top.sv =====
// ---------------------------------------------------------------------------
// windowed_detector_rate_counter_top
// Path: a closing event is held in the input register, then its report in the result register.
// Throughput: one event per cycle; the core takes the held event whenever the
// result register is empty or being read in the same cycle.
// Reset (synchronous, active low) clears window, counters, round count, the
// finished flag and both valid flags; configuration returns to 2^32 and 1.
// ---------------------------------------------------------------------------
module windowed_detector_rate_counter_top import wdrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [WORD_W-1:0]     i_high_word,
    input  logic [WORD_W-1:0]     i_low_word,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [WORD_W-1:0]     o_count_any,
    output logic [WORD_W-1:0]     o_count_det_a,
    output logic [WORD_W-1:0]     o_count_det_b,
    output logic [WORD_W-1:0]     o_count_det_c,
    output logic [WORD_W-1:0]     o_count_det_d,
    output logic                  o_final_round
);

    t_cfg  cfg;
    t_evt  evt;
    logic  take;
    t_word count_det [REPORTED];

    wdrc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wdrc_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_high_word (i_high_word),
        .i_low_word  (i_low_word),
        .i_take      (take),
        .o_evt       (evt)
    );

    wdrc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_evt         (evt),
        .i_cfg         (cfg),
        .i_out_ready   (i_ready),
        .o_take        (take),
        .o_out_valid   (o_valid),
        .o_count_any   (o_count_any),
        .o_count_det   (count_det),
        .o_final_round (o_final_round)
    );

    assign o_count_det_a = count_det[0];
    assign o_count_det_b = count_det[1];
    assign o_count_det_c = count_det[2];
    assign o_count_det_d = count_det[3];

endmodule

// ===== hdl/wdrc_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// wdrc_cfg_regs
// Configuration registers: window length and round limit.
// ---------------------------------------------------------------------------
module wdrc_cfg_regs import wdrc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_WINDOW_LENGTH: n_cfg.window_length = i_cfg_data[TIME_W-1:0];
                REG_ROUND_LIMIT:   n_cfg.round_limit   = i_cfg_data[LIMIT_W-1:0];
                default:           n_cfg               = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length <= WINDOW_RESET;
            r_cfg.round_limit   <= LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/wdrc_in_stage.sv =====
// ---------------------------------------------------------------------------
// wdrc_in_stage
// Input register: holds one event transaction until the core takes it.
// ---------------------------------------------------------------------------
module wdrc_in_stage import wdrc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_word i_high_word,
    input  t_word i_low_word,
    input  logic  i_take,
    output t_evt  o_evt
);

    logic  r_valid;
    t_word r_high_word;
    t_word r_low_word;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_high_word <= i_high_word;
            r_low_word  <= i_low_word;
        end
    end

    assign o_evt = '{valid: r_valid, high_word: r_high_word, low_word: r_low_word};

endmodule

// ===== hdl/wdrc_core.sv =====
// ---------------------------------------------------------------------------
// wdrc_core
// Window tracking, saturating counters, round bookkeeping and result register.
// ---------------------------------------------------------------------------
module wdrc_core import wdrc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_evt  i_evt,
    input  t_cfg  i_cfg,
    input  logic  i_out_ready,
    output logic  o_take,
    output logic  o_out_valid,
    output t_word o_count_any,
    output t_word o_count_det [REPORTED],
    output logic  o_final_round
);

    logic               r_open,     n_open;
    logic               r_finished, n_finished;
    logic [WEND_W-1:0]  r_wend,     n_wend;
    logic [LIMIT_W-1:0] r_rounds,   n_rounds;
    t_cnt               r_any,      n_any;
    t_cnt               r_det [DETECTORS];
    t_cnt               n_det [DETECTORS];

    logic  r_out_valid, n_out_valid;
    t_word r_rep_any,   n_rep_any;
    t_word r_rep_det [REPORTED];
    t_word n_rep_det [REPORTED];
    logic  r_rep_final, n_rep_final;

    logic [TIME_W-1:0]    ev_time;
    logic [DETECTORS-1:0] hits;
    t_cnt                 inc_any;
    t_cnt                 inc_det [DETECTORS];

    assign o_take  = i_evt.valid && (!r_out_valid || i_out_ready);
    assign ev_time = {i_evt.high_word[TIME_W-WORD_W+TIME_LO_BIT-1:0],
                      i_evt.low_word[WORD_W-1:TIME_LO_BIT]};
    assign hits    = i_evt.low_word[DETECTORS-1:0];

    always_comb begin
        inc_any = (|hits) ? sat_inc(r_any) : r_any;
        for (int j = 0; j < DETECTORS; j++) begin
            inc_det[j] = hits[j] ? sat_inc(r_det[j]) : r_det[j];
        end
    end

    always_comb begin
        n_open      = r_open;
        n_finished  = r_finished;
        n_wend      = r_wend;
        n_rounds    = r_rounds;
        n_any       = r_any;
        n_det       = r_det;
        n_out_valid = r_out_valid && !i_out_ready;
        n_rep_any   = r_rep_any;
        n_rep_det   = r_rep_det;
        n_rep_final = r_rep_final;

        if (o_take && !r_finished) begin
            if (!r_open) begin
                // first event of a round only opens the window
                n_open = 1'b1;
                n_wend = {1'b0, ev_time} + {1'b0, i_cfg.window_length};
                n_any  = '0;
                for (int j = 0; j < DETECTORS; j++) n_det[j] = '0;
            end else if ({1'b0, ev_time} > r_wend) begin
                // closing event is counted, then reported
                n_out_valid = 1'b1;
                n_rep_any   = clamp_report(inc_any);
                for (int j = 0; j < REPORTED; j++) begin
                    n_rep_det[j] = (j < DETECTORS) ? clamp_report(inc_det[j]) : '0;
                end
                n_rounds    = r_rounds + LIMIT_W'(1);
                n_rep_final = (i_cfg.round_limit != '0) && (n_rounds == i_cfg.round_limit);
                n_finished  = n_rep_final;
                n_open      = 1'b0;
                n_any       = '0;
                for (int j = 0; j < DETECTORS; j++) n_det[j] = '0;
            end else begin
                n_any = inc_any;
                n_det = inc_det;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_finished  <= 1'b0;
            r_wend      <= '0;
            r_rounds    <= '0;
            r_any       <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < DETECTORS; j++) r_det[j] <= '0;
        end else begin
            r_open      <= n_open;
            r_finished  <= n_finished;
            r_wend      <= n_wend;
            r_rounds    <= n_rounds;
            r_any       <= n_any;
            r_det       <= n_det;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep_any   <= n_rep_any;
        r_rep_det   <= n_rep_det;
        r_rep_final <= n_rep_final;
    end

    assign o_out_valid   = r_out_valid;
    assign o_count_any   = r_rep_any;
    assign o_count_det   = r_rep_det;
    assign o_final_round = r_rep_final;

endmodule

// ===== hdl/wdrc_checker.sv =====
// ---------------------------------------------------------------------------
// wdrc_checker
// Port-level checks on the windowed detector rate counter, bound to the top.
// ---------------------------------------------------------------------------
`include "windowed_detector_rate_counter_top_macros.svh"

module wdrc_checker import wdrc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_ready,
    input logic [WORD_W-1:0] o_count_any,
    input logic [WORD_W-1:0] o_count_det_a,
    input logic [WORD_W-1:0] o_count_det_b,
    input logic [WORD_W-1:0] o_count_det_c,
    input logic [WORD_W-1:0] o_count_det_d,
    input logic              o_final_round
);

    logic                out_stall;
    logic                out_fire;
    logic                dets_bounded;
    logic [5*WORD_W:0]   report_bits;

    assign out_stall    = o_valid && !i_ready;
    assign out_fire     = o_valid && i_ready;
    assign report_bits  = {o_count_any, o_count_det_a, o_count_det_b,
                           o_count_det_c, o_count_det_d, o_final_round};
    assign dets_bounded = (o_count_any >= o_count_det_a) && (o_count_any >= o_count_det_b) &&
                          (o_count_any >= o_count_det_c) && (o_count_any >= o_count_det_d);

    // no report may be pending straight after reset
    `WDRC_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_valid, "report valid after reset")

    // a stalled report keeps its payload
    `WDRC_ASSERT(a_out_hold, out_stall |=> o_valid && $stable(report_bits), "report not held")

    // any-detector count bounds every single-detector count
    `WDRC_ASSERT(a_any_bounds, o_valid |-> dets_bounded, "per-detector count exceeds any count")

    // nothing follows the final round's report
    `WDRC_ASSERT(a_final_last, out_fire && o_final_round |=> !o_valid, "report after final")

endmodule

bind windowed_detector_rate_counter_top wdrc_checker u_wdrc_checker (.*);
